// ===== hdl/cde_pkg.sv =====
package cde_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_REAR  = 3'd3,
    MODE_PEEK      = 3'd4
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage

// ===== hdl/cde_ctrl.sv =====
module cde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cde_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.accept   = in_valid_i && in_ready_q;
    cmd_o.load_out = (state_q == S_READ) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new load is simply replaced.
      if (out_valid_q && out_ready_i && !cmd_o.load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_READ;
            in_ready_q <= 1'b0;
          end
        end
        S_READ: begin
          // Wait here while the previous result still occupies the output register.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/cde_datapath.sv =====
module cde_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cde_pkg::cmd_t                      cmd_i,
  input  logic                               cfg_we_i,
  input  logic        [cde_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic        [cde_pkg::MODE_W-1:0]  mode_i,
  input  logic signed [cde_pkg::DATA_W-1:0]  data_in_i,
  output logic                               success_o,
  output logic signed [cde_pkg::DATA_W-1:0]  front_value_o,
  output logic signed [cde_pkg::DATA_W-1:0]  rear_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic        [cde_pkg::CNT_W-1:0]   occupancy_o
);

  localparam int unsigned IW = cde_pkg::IDX_W;
  localparam int unsigned CW = cde_pkg::CNT_W;
  localparam int unsigned DW = cde_pkg::DATA_W;

  logic [DW-1:0] mem [cde_pkg::DEPTH];

  logic [CW-1:0] cap_q, cap_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          ok_q, ok_d;
  logic          wr_en;
  logic [IW-1:0] wr_idx;

  logic          success_q;
  logic [DW-1:0] front_q, rear_q;
  logic          empty_q, full_q;
  logic [CW-1:0] occ_q;

  function automatic logic [IW-1:0] step_up(logic [IW-1:0] i, logic [CW-1:0] cap);
    logic [CW:0] nxt;
    nxt = (CW+1)'(i) + (CW+1)'(1);
    return (nxt >= (CW+1)'(cap)) ? '0 : nxt[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_down(logic [IW-1:0] i, logic [CW-1:0] cap);
    logic [CW-1:0] last;
    last = cap - CW'(1);
    return ((i == '0) || ((CW+1)'(i) >= (CW+1)'(cap))) ? last[IW-1:0] : i - IW'(1);
  endfunction

  // Written capacity is clamped to the range one to the store depth.
  function automatic logic [CW-1:0] clamp_cap(logic [cde_pkg::CAP_W-1:0] v);
    int unsigned w;
    w = int'(v);
    if (w == 0) begin
      w = 1;
    end else if (w > cde_pkg::DEPTH) begin
      w = cde_pkg::DEPTH;
    end
    return CW'(w);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    ok_d    = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = head_q;
    case (mode_i)
      cde_pkg::MODE_INS_FRONT: begin
        if (count_q < cap_q) begin
          head_d  = step_down(head_q, cap_q);
          wr_en   = 1'b1;
          wr_idx  = head_d;
          count_d = count_q + CW'(1);
          if (count_q == '0) begin
            tail_d = head_d;
          end
          ok_d = 1'b1;
        end
      end
      cde_pkg::MODE_INS_REAR: begin
        if (count_q < cap_q) begin
          tail_d  = step_up(tail_q, cap_q);
          wr_en   = 1'b1;
          wr_idx  = tail_d;
          count_d = count_q + CW'(1);
          if (count_q == '0) begin
            head_d = tail_d;
          end
          ok_d = 1'b1;
        end
      end
      cde_pkg::MODE_DEL_FRONT: begin
        if (count_q != '0) begin
          head_d  = step_up(head_q, cap_q);
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      cde_pkg::MODE_DEL_REAR: begin
        if (count_q != '0) begin
          tail_d  = step_down(tail_q, cap_q);
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      cde_pkg::MODE_PEEK: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign cap_d = clamp_cap(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CW'(cde_pkg::DEPTH);
      head_q  <= '0;
      tail_q  <= IW'(cde_pkg::DEPTH - 1);
      count_q <= '0;
      ok_q    <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q   <= cap_d;
      head_q  <= '0;
      tail_q  <= IW'(cap_d - CW'(1));
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem[wr_idx] <= data_in_i;
    end
  end

  // The result is read from the store in the read state that follows the update,
  // straight into the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      success_q <= ok_q;
      front_q   <= (count_q == '0) ? '1 : mem[head_q];
      rear_q    <= (count_q == '0) ? '1 : mem[tail_q];
      empty_q   <= (count_q == '0);
      full_q    <= (count_q == cap_q);
      occ_q     <= count_q;
    end
  end

  assign success_o     = success_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;
  assign occupancy_o   = occ_q;

endmodule

// ===== hdl/circular_deque_engine_top.sv =====
// Each transaction updates the deque pointers when accepted; its result is then read
// from the store into the output register, from which it can be taken.
// A new transaction is not accepted until the store read of the last one is done,
// and a result not yet taken stalls the read step.
// A new input is accepted while a finished result still waits at the output.
// Reset (rst_ni low, asynchronous) empties the deque and sets capacity to 16;
// store contents are not cleared, and a capacity write also empties the deque.
module circular_deque_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [cde_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [cde_pkg::MODE_W-1:0]  mode_i,
  input  logic signed [cde_pkg::DATA_W-1:0]  data_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               success_o,
  output logic signed [cde_pkg::DATA_W-1:0]  front_value_o,
  output logic signed [cde_pkg::DATA_W-1:0]  rear_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic        [cde_pkg::CNT_W-1:0]   occupancy_o
);

  cde_pkg::cmd_t cmd;

  cde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cde_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .data_in_i     (data_in_i),
    .success_o     (success_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

// ===== hdl/cde_checker.sv =====
module cde_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [cde_pkg::DATA_W-1:0]  front_value_o,
  input logic signed [cde_pkg::DATA_W-1:0]  rear_value_o,
  input logic                               is_empty_o,
  input logic                               is_full_o,
  input logic        [cde_pkg::CNT_W-1:0]   occupancy_o
);

  // A result that is stalled keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_value_o)
      && $stable(rear_value_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  // Only one transaction is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> occupancy_o == '0 && front_value_o == '1
      && rear_value_o == '1)
    else $error("empty result is inconsistent");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0)) && !(is_empty_o && is_full_o))
    else $error("status flags are inconsistent");

endmodule

bind circular_deque_engine_top cde_checker u_cde_checker (.*);

// ===== test/deque_checker.sv =====
module deque_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cde_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [cde_pkg::MODE_W-1:0]        mode_i,
  input  logic [cde_pkg::DATA_W-1:0]        data_in_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              success_i,
  input  logic [cde_pkg::DATA_W-1:0]        front_value_i,
  input  logic [cde_pkg::DATA_W-1:0]        rear_value_i,
  input  logic                              is_empty_i,
  input  logic                              is_full_i,
  input  logic [cde_pkg::CNT_W-1:0]         occupancy_i,
  output int unsigned                       error_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       results_o,
  output int unsigned                       refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH  = cde_pkg::DEPTH;
  localparam int unsigned DATA_W = cde_pkg::DATA_W;
  localparam int unsigned IDX_W  = cde_pkg::IDX_W;
  localparam int unsigned CNT_W  = cde_pkg::CNT_W;
  localparam int unsigned CAP_W  = cde_pkg::CAP_W;
  localparam int unsigned MODE_W = cde_pkg::MODE_W;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  occ;
  } deque_view_t;

  // Shadow copy of the deque.
  logic [DATA_W-1:0] slots [DEPTH];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  fill;
  logic [CAP_W-1:0]  cap_reg;

  deque_view_t awaited_views [$];

  // A capacity of zero acts as one, and anything above the store size saturates.
  function automatic int unsigned usable_slots();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic logic [IDX_W-1:0] slot_up(logic [IDX_W-1:0] i, int unsigned lim);
    int unsigned n;
    n = int'(i) + 1;
    return (n >= lim) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] slot_down(logic [IDX_W-1:0] i, int unsigned lim);
    if (i == '0 || int'(i) >= lim) return IDX_W'(lim - 1);
    return i - 1'b1;
  endfunction

  function automatic void clear_deque();
    head = '0;
    tail = IDX_W'(usable_slots() - 1);
    fill = '0;
  endfunction

  function automatic deque_view_t deque_apply(logic [MODE_W-1:0] op, logic [DATA_W-1:0] value);
    deque_view_t v;
    int unsigned lim;
    lim = usable_slots();
    v = '0;
    case (op)
      cde_pkg::MODE_INS_FRONT: begin
        if (fill < lim) begin
          head = slot_down(head, lim);
          slots[head] = value;
          fill = fill + 1'b1;
          if (fill == 1) tail = head;
          v.ok = 1'b1;
        end
      end
      cde_pkg::MODE_INS_REAR: begin
        if (fill < lim) begin
          tail = slot_up(tail, lim);
          slots[tail] = value;
          fill = fill + 1'b1;
          if (fill == 1) head = tail;
          v.ok = 1'b1;
        end
      end
      cde_pkg::MODE_DEL_FRONT: begin
        if (fill != '0) begin
          head = slot_up(head, lim);
          fill = fill - 1'b1;
          v.ok = 1'b1;
        end
      end
      cde_pkg::MODE_DEL_REAR: begin
        if (fill != '0) begin
          tail = slot_down(tail, lim);
          fill = fill - 1'b1;
          v.ok = 1'b1;
        end
      end
      cde_pkg::MODE_PEEK: v.ok = 1'b1;
      default: v.ok = 1'b0;
    endcase
    if (fill == '0) begin
      v.front = '1;
      v.rear  = '1;
    end else begin
      v.front = slots[head];
      v.rear  = slots[tail];
    end
    v.empty = (fill == '0);
    v.full  = (fill == lim);
    v.occ   = fill;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count_o++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] seen,
                             input logic [DATA_W-1:0] predicted);
    if (seen !== predicted)
      flag_error($sformatf("%s is 0x%0h, predicted 0x%0h", name, seen, predicted));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deque_view_t want;
    if (!rst_ni) begin
      cap_reg = CAP_W'(DEPTH);
      clear_deque();
      awaited_views.delete();
      error_count_o = 0;
      pending_o = 0;
      results_o = 0;
      refusals_o = 0;
    end else begin
      // A result always belongs to an earlier transaction, so compare before predicting.
      if (out_valid_i && out_ready_i) begin
        if (awaited_views.size() == 0) begin
          flag_error("result arrived with no transaction waiting");
        end else begin
          want = awaited_views.pop_front();
          check_field("success", success_i, want.ok);
          check_field("front_value", front_value_i, want.front);
          check_field("rear_value", rear_value_i, want.rear);
          check_field("is_empty", is_empty_i, want.empty);
          check_field("is_full", is_full_i, want.full);
          check_field("occupancy", occupancy_i, want.occ);
          results_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = deque_apply(mode_i, data_in_i);
        if (!want.ok) refusals_o++;
        awaited_views = {awaited_views, want};
      end
      if (cfg_we_i) begin
        cap_reg = cfg_wdata_i;
        clear_deque();
      end
      pending_o = awaited_views.size();
    end
  end

endmodule

// ===== test/circular_deque_engine_top_tb.sv =====
module circular_deque_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_W = cde_pkg::DATA_W;
  localparam int unsigned CNT_W  = cde_pkg::CNT_W;
  localparam int unsigned CAP_W  = cde_pkg::CAP_W;
  localparam int unsigned MODE_W = cde_pkg::MODE_W;

  localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_C = 3'd7;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 105;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CAP_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [MODE_W-1:0]        mode_i;
  logic signed [DATA_W-1:0] data_in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     success_o;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] rear_value_o;
  logic                     is_empty_o;
  logic                     is_full_o;
  logic [CNT_W-1:0]         occupancy_o;

  int unsigned error_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned refusals;

  int unsigned holdoffs_asked;
  int unsigned holdoffs_done;
  int unsigned sent_count;
  int unsigned settings_used;

  circular_deque_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_in_i     (data_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .occupancy_o   (occupancy_o)
  );

  deque_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .mode_i        (mode_i),
    .data_in_i     (data_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_i     (success_o),
    .front_value_i (front_value_o),
    .rear_value_i  (rear_value_o),
    .is_empty_i    (is_empty_o),
    .is_full_i     (is_full_o),
    .occupancy_i   (occupancy_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .results_o     (results_seen),
    .refusals_o    (refusals)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 19))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // The insert bias shifts over a phase so the deque is driven both to full and to empty.
  function automatic logic [MODE_W-1:0] pick_mode(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return MODE_W'($urandom_range(int'(MODE_RSVD_A), int'(MODE_RSVD_C)));
    if (r < 10) return cde_pkg::MODE_PEEK;
    if ($urandom_range(0, 99) < insert_pct)
      return $urandom_range(0, 1) ? cde_pkg::MODE_INS_FRONT : cde_pkg::MODE_INS_REAR;
    return $urandom_range(0, 1) ? cde_pkg::MODE_DEL_FRONT : cde_pkg::MODE_DEL_REAR;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Entered and left at a falling edge; valid stays high until the transaction is taken.
  task automatic send_op(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d,
                         input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    data_in_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_for_drain(4);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // Receiver: mostly ready, with short and occasional long pauses, plus the
  // long hold-offs the stimulus asks for.
  initial begin
    int unsigned r;
    int unsigned n;
    logic lvl;
    out_ready_i = 1'b0;
    holdoffs_done = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (holdoffs_asked != holdoffs_done) begin
        lvl = 1'b0;
        n = HOLD_CYCLES;
        holdoffs_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          lvl = 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 95) begin
          lvl = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          n = $urandom_range(10, 30);
        end
      end
      out_ready_i <= lvl;
      repeat (n) @(negedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout: the run did not drain in time");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] cap_plan [PHASES];
    int unsigned insert_pct;
    bit no_gaps;

    cap_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd8, 5'd15, 5'd5, 5'd0};
    cap_plan[PHASES-1] = CAP_W'($urandom_range(0, 31));

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = cde_pkg::MODE_PEEK;
    data_in_i = '0;
    holdoffs_asked = 0;
    sent_count = 0;
    settings_used = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty deque at the reset capacity, including the wrap of the
    // rear pointer from its reset position.
    send_op(cde_pkg::MODE_DEL_FRONT, $urandom(), 0);
    send_op(cde_pkg::MODE_DEL_REAR, $urandom(), 1);
    send_op(cde_pkg::MODE_PEEK, $urandom(), 0);
    send_op(MODE_RSVD_A, $urandom(), 0);
    send_op(cde_pkg::MODE_INS_REAR, 32'h7FFF_FFFF, 2);
    send_op(cde_pkg::MODE_INS_FRONT, 32'h8000_0000, 0);
    send_op(cde_pkg::MODE_DEL_REAR, $urandom(), 0);
    send_op(cde_pkg::MODE_DEL_FRONT, $urandom(), 0);

    // Directed: a small deque taken to full, refused at both ends, then drained.
    write_capacity(5'd3);
    send_op(cde_pkg::MODE_INS_FRONT, 32'hFFFF_FFFF, 0);
    send_op(cde_pkg::MODE_INS_REAR, 32'h0000_0000, 0);
    send_op(cde_pkg::MODE_INS_FRONT, 32'h5555_5555, 0);
    send_op(cde_pkg::MODE_INS_REAR, 32'hAAAA_AAAA, 0);
    send_op(cde_pkg::MODE_INS_FRONT, 32'h0000_0001, 3);
    send_op(MODE_RSVD_B, $urandom(), 0);
    send_op(MODE_RSVD_C, $urandom(), 0);
    send_op(cde_pkg::MODE_PEEK, $urandom(), 0);
    send_op(cde_pkg::MODE_DEL_FRONT, $urandom(), 0);
    send_op(cde_pkg::MODE_INS_REAR, 32'h1234_5678, 0);
    send_op(cde_pkg::MODE_DEL_REAR, $urandom(), 0);
    send_op(cde_pkg::MODE_DEL_REAR, $urandom(), 1);
    send_op(cde_pkg::MODE_DEL_FRONT, $urandom(), 0);
    send_op(cde_pkg::MODE_DEL_REAR, $urandom(), 0);

    insert_pct = 50;
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      no_gaps = (p % 4 == 3);
      // During these phases the output side is held off while items keep coming.
      if (p == 3 || p == 7) holdoffs_asked++;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 19) == 0) insert_pct = $urandom_range(0, 2) * 40 + 10;
        send_op(pick_mode(insert_pct), pick_data(), no_gaps ? 0 : pick_gap());
      end
    end

    wait_for_drain(10);

    $display("Covered %0d transactions under %0d capacity settings, zero and oversize included.",
             sent_count, settings_used + 1);
    $display("%0d results checked, %0d operations refused, %0d long output hold-offs.",
             results_seen, refusals, holdoffs_done);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
